// ===== src/gn3d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gn3d_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int COORD_W       = 32;
    localparam int OUT_W         = 16;
    localparam int CELL_W        = 8;

    localparam int FW = FRAC_BITS + 5;
    localparam int WW = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 3;
    localparam int PW = 2 * FRAC_BITS + 6;
    localparam int XW = NW + OUT_FRAC_BITS + 1;

    localparam int SH_DN = (FRAC_BITS >= OUT_FRAC_BITS) ? FRAC_BITS - OUT_FRAC_BITS : 0;
    localparam int SH_UP = (FRAC_BITS < OUT_FRAC_BITS) ? OUT_FRAC_BITS - FRAC_BITS : 0;

    typedef logic        [FRAC_BITS-1:0] t_frac;
    typedef logic        [CELL_W-1:0]    t_cell;
    typedef logic signed [FW-1:0]        t_fw;
    typedef logic signed [WW-1:0]        t_wt;
    typedef logic signed [NW-1:0]        t_noise;
    typedef logic signed [PW-1:0]        t_prod;
    typedef logic signed [XW-1:0]        t_wide;
    typedef logic        [3:0]           t_gidx;
    typedef logic        [5:0]           t_grad;

    localparam t_wt   ONE      = t_wt'(1) <<< FRAC_BITS;
    localparam t_prod RND_HALF = t_prod'(1) <<< (FRAC_BITS - 1);
    localparam t_wide OUT_BIAS = (SH_DN == 0) ? t_wide'(0) : (t_wide'(1) <<< (SH_DN - 1));
    localparam t_wide OUT_MAX  = t_wide'(32767);
    localparam t_wide OUT_MIN  = -t_wide'(32768);

    localparam logic [7:0] PERM [256] = '{
        151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,
        8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,
        35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,
        134,139,48,27,166,77,146,158,231,83,111,229,122,60,211,133,230,220,105,92,41,
        55,46,245,40,244,102,143,54,65,25,63,161,1,216,80,73,209,76,132,187,208,89,
        18,169,200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,52,217,226,
        250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,59,227,47,16,58,17,182,
        189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,
        172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,
        228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,
        107,49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
        138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
    };

    typedef t_gidx t_gidx_tab [256];

    function automatic t_gidx_tab build_hash_grad();
        t_gidx_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = t_gidx'(PERM[i] % 12);
        end
        return tab;
    endfunction

    localparam t_gidx_tab HASH_GRAD = build_hash_grad();

    // components x,y,z as 2-bit signed
    localparam t_grad GRAD_TABLE [12] = '{
        6'b01_01_00, 6'b11_01_00, 6'b01_11_00, 6'b11_11_00,
        6'b01_00_01, 6'b11_00_01, 6'b01_00_11, 6'b11_00_11,
        6'b00_01_01, 6'b00_11_01, 6'b00_01_11, 6'b00_11_11
    };

    function automatic t_noise grad_term(logic [1:0] c, t_wt o);
        t_noise r;
        unique case (c)
            2'b01:   r = t_noise'(o);
            2'b11:   r = -t_noise'(o);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_noise grad_dot(t_gidx gi, t_wt ox, t_wt oy, t_wt oz);
        t_grad g;
        g = (gi < 4'd12) ? GRAD_TABLE[gi] : '0;
        return grad_term(g[5:4], ox) + grad_term(g[3:2], oy) + grad_term(g[1:0], oz);
    endfunction

    // round half up, then drop FRAC_BITS
    function automatic t_prod rnd(t_prod v);
        return (v + RND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic t_noise mix(t_noise p, t_noise q, t_wt w);
        t_prod d;
        t_prod prod;
        d    = t_prod'(q) - t_prod'(p);
        prod = d * t_prod'(w);
        return p + t_noise'(rnd(prod));
    endfunction

endpackage
`default_nettype wire

// ===== src/gn3d_fade.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gn3d_fade import gn3d_pkg::*; (
    input  wire logic  i_clk,
    input  wire t_frac i_frac,
    output t_wt        o_w
);

    t_fw   f0, n_b, n_c, n_d;
    t_prod n_p1, n_p2, n_p3, n_p4, e;
    t_frac r_f1, r_f2, r_f3;
    t_prod r_p1, r_p2, r_p3, r_p4;
    t_wt   r_w;

    always_comb begin
        f0   = t_fw'({1'b0, i_frac});
        n_p1 = t_prod'(t_fw'(6) * f0 - t_fw'(15) * t_fw'(ONE)) * t_prod'(f0);
        n_b  = t_fw'(rnd(r_p1)) + t_fw'(10) * t_fw'(ONE);
        n_p2 = t_prod'(n_b) * t_prod'({1'b0, r_f1});
        n_c  = t_fw'(rnd(r_p2));
        n_p3 = t_prod'(n_c) * t_prod'({1'b0, r_f2});
        n_d  = t_fw'(rnd(r_p3));
        n_p4 = t_prod'(n_d) * t_prod'({1'b0, r_f3});
        e    = rnd(r_p4);
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= i_frac;
        r_f2 <= r_f1;
        r_f3 <= r_f2;
        r_p1 <= n_p1;
        r_p2 <= n_p2;
        r_p3 <= n_p3;
        r_p4 <= n_p4;
        if (e < 0) begin
            r_w <= '0;
        end else if (e > t_prod'(ONE)) begin
            r_w <= ONE;
        end else begin
            r_w <= t_wt'(e);
        end
    end

    assign o_w = r_w;

endmodule
`default_nettype wire

// ===== src/gn3d_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gn3d_hash import gn3d_pkg::*; (
    input  wire logic  i_clk,
    input  wire t_cell i_cx,
    input  wire t_cell i_cy,
    input  wire t_cell i_cz,
    input  wire t_frac i_fx,
    input  wire t_frac i_fy,
    input  wire t_frac i_fz,
    output t_noise     o_n [8]
);

    t_cell  r_hz [2];
    t_cell  r_hy [4];
    t_gidx  r_gi [8];
    t_noise r_n  [8];
    t_cell  r_cx1, r_cx2, r_cy1;
    t_frac  r_fx [3];
    t_frac  r_fy [3];
    t_frac  r_fz [3];
    t_wt    ox [2];
    t_wt    oy [2];
    t_wt    oz [2];

    always_comb begin
        ox[0] = t_wt'({1'b0, r_fx[2]});
        oy[0] = t_wt'({1'b0, r_fy[2]});
        oz[0] = t_wt'({1'b0, r_fz[2]});
        ox[1] = ox[0] - ONE;
        oy[1] = oy[0] - ONE;
        oz[1] = oz[0] - ONE;
    end

    always_ff @(posedge i_clk) begin
        r_hz[0] <= PERM[i_cz];
        r_hz[1] <= PERM[i_cz + t_cell'(1)];
        r_cy1   <= i_cy;
        r_cx1   <= i_cx;
        r_cx2   <= r_cx1;
        r_fx[0] <= i_fx;
        r_fy[0] <= i_fy;
        r_fz[0] <= i_fz;
        for (int s = 1; s < 3; s++) begin
            r_fx[s] <= r_fx[s-1];
            r_fy[s] <= r_fy[s-1];
            r_fz[s] <= r_fz[s-1];
        end
        for (int j = 0; j < 4; j++) begin
            r_hy[j] <= PERM[r_cy1 + t_cell'(j >> 1) + r_hz[j & 1]];
        end
        for (int i = 0; i < 8; i++) begin
            r_gi[i] <= HASH_GRAD[r_cx2 + t_cell'(i >> 2) + r_hy[i & 3]];
        end
        for (int i = 0; i < 8; i++) begin
            r_n[i] <= grad_dot(r_gi[i], ox[(i >> 2) & 1], oy[(i >> 1) & 1], oz[i & 1]);
        end
    end

    assign o_n = r_n;

endmodule
`default_nettype wire

// ===== src/gn3d_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gn3d_blend import gn3d_pkg::*; (
    input  wire logic   i_clk,
    input  wire t_noise i_n [8],
    input  wire t_wt    i_wx,
    input  wire t_wt    i_wy,
    input  wire t_wt    i_wz,
    output logic signed [OUT_W-1:0] o_value
);

    t_noise r_n [8];
    t_noise r_x [4];
    t_noise r_y [2];
    t_noise r_r;
    t_wt    r_wy1, r_wz1, r_wz2;
    t_wide  rr;
    logic signed [OUT_W-1:0] r_out;

    always_comb begin
        rr = ((t_wide'(r_r) + OUT_BIAS) >>> SH_DN) <<< SH_UP;
    end

    always_ff @(posedge i_clk) begin
        r_n   <= i_n;
        r_wy1 <= i_wy;
        r_wz1 <= i_wz;
        r_wz2 <= r_wz1;
        for (int j = 0; j < 4; j++) begin
            r_x[j] <= mix(r_n[j], r_n[j+4], i_wx);
        end
        for (int k = 0; k < 2; k++) begin
            r_y[k] <= mix(r_x[k], r_x[k+2], r_wy1);
        end
        r_r <= mix(r_y[0], r_y[1], r_wz2);
        if (rr > OUT_MAX) begin
            r_out <= OUT_W'(OUT_MAX);
        end else if (rr < OUT_MIN) begin
            r_out <= OUT_W'(OUT_MIN);
        end else begin
            r_out <= OUT_W'(rr);
        end
    end

    assign o_value = r_out;

endmodule
`default_nettype wire

// ===== src/gradient_noise_3d.sv =====
// channel  | ports                                 | beat
// point    | start, busy, i_coord_x/y/z            | start high while busy low
// noise    | o_valid, o_noise_value                | o_valid high for one cycle
//
// ten-stage pipeline: fade is four chained multiplies, hash is three rom lookups
// a point can start every cycle; its result leaves the last stage together with o_valid
// busy is held low, the pipeline never stalls and results cannot be held off
// synchronous active-low reset clears the valid chain only
`timescale 1ns / 1ps
`default_nettype none
module gradient_noise_3d import gn3d_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    input  wire logic signed [COORD_W-1:0] i_coord_z,
    output logic                           o_valid,
    output logic signed [OUT_W-1:0]        o_noise_value
);

    localparam int DEPTH = 10;

    logic [DEPTH-1:0] r_vld;
    t_cell  r_cx, r_cy, r_cz;
    t_frac  r_fx, r_fy, r_fz;
    t_wt    wx, wy, wz;
    t_noise n [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx <= i_coord_x[FRAC_BITS +: CELL_W];
        r_cy <= i_coord_y[FRAC_BITS +: CELL_W];
        r_cz <= i_coord_z[FRAC_BITS +: CELL_W];
        r_fx <= i_coord_x[FRAC_BITS-1:0];
        r_fy <= i_coord_y[FRAC_BITS-1:0];
        r_fz <= i_coord_z[FRAC_BITS-1:0];
    end

    gn3d_fade u_fade_x (.i_clk(i_clk), .i_frac(r_fx), .o_w(wx));
    gn3d_fade u_fade_y (.i_clk(i_clk), .i_frac(r_fy), .o_w(wy));
    gn3d_fade u_fade_z (.i_clk(i_clk), .i_frac(r_fz), .o_w(wz));

    gn3d_hash u_hash (
        .i_clk(i_clk),
        .i_cx (r_cx),
        .i_cy (r_cy),
        .i_cz (r_cz),
        .i_fx (r_fx),
        .i_fy (r_fy),
        .i_fz (r_fz),
        .o_n  (n)
    );

    gn3d_blend u_blend (
        .i_clk  (i_clk),
        .i_n    (n),
        .i_wx   (wx),
        .i_wy   (wy),
        .i_wz   (wz),
        .o_value(o_noise_value)
    );

    assign busy    = 1'b0;
    assign o_valid = r_vld[DEPTH-1];

`ifndef SYNTH
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, DEPTH))
        else $error("result beat without a matching start");
    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_chain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_vld[DEPTH-2]) |-> o_valid)
        else $error("beat lost in valid chain");
`endif

endmodule
`default_nettype wire
